// File: rtl/core/bbg_pkg.sv
// ============================================================================
// bbg_pkg
// Shared types and constants of the bipolar bar graph column generator.
// ============================================================================
package bbg_pkg;

    // Display row
    localparam int FIRST_COLUMN = 3;
    localparam int LAST_COLUMN  = 16;
    localparam int COL_W        = 5;

    // Field widths
    localparam int ENERGY_W = 11;
    localparam int MAXE_W   = 10;
    localparam int MINE_W   = 11;
    localparam int IND_W    = 4;
    localparam int GLYPH_W  = 4;
    localparam int LIGHT_W  = 2;

    // Indicator shows a centered glyph while |energy| <= IND_SWING
    localparam int IND_SWING  = 2;
    // Nonzero tip remainder codes up to this value give a half cell
    localparam int HALF_LIMIT = 3;

    // Column span arithmetic (signed, holds LAST_COLUMN - indicator)
    localparam int SPAN_W = $clog2(LAST_COLUMN + 1) + 2;

    // Shared divider: 11-bit magnitudes (up to 1024), 4 quotient bits per cycle
    localparam int DIV_W     = 11;
    localparam int DIV_STEP  = 4;
    localparam int DIV_ITER  = (DIV_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_PAD   = DIV_ITER * DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

    // scale / 5 as (scale * 1639) >> 13, exact for scale < 2731
    localparam int DIV5_MUL   = 1639;
    localparam int DIV5_MUL_W = 11;
    localparam int DIV5_SHIFT = 13;
    localparam int STEP5_W    = 8;
    localparam int PROD_W     = DIV_W + DIV5_MUL_W;

    // Signed tip column: quotient magnitude plus indicator column
    localparam int TIP_W = DIV_W + 1;

    // Queue between front and back, power of two
    localparam int QDEPTH = 2;

    // Configuration port
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;
    localparam int PDATA_W   = 32;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ENERGY = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_ENERGY = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INDICATOR  = 2'd2;

    localparam logic [MAXE_W-1:0]        MAX_ENERGY_RST = 10'd100;
    localparam logic signed [MINE_W-1:0] MIN_ENERGY_RST = -11'sd50;
    localparam logic [IND_W-1:0]         INDICATOR_RST  = 4'd8;

    typedef enum logic [GLYPH_W-1:0] {
        G_BLANK    = 4'd0,
        G_POS_HALF = 4'd1,
        G_FULL     = 4'd2,
        G_NEG_HALF = 4'd3,
        G_IND_NEG  = 4'd4,
        G_IND      = 4'd5,
        G_IND_POS  = 4'd6,
        G_SPACE    = 4'd8
    } glyph_t;

    typedef enum logic [LIGHT_W-1:0] {
        L_NONE   = 2'd0,
        L_GREEN  = 2'd1,
        L_YELLOW = 2'd2,
        L_RED    = 2'd3
    } light_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SCALE,
        F_QUOT,
        F_PART,
        F_PUSH
    } front_state_t;

    typedef struct packed {
        logic [MAXE_W-1:0]        max_energy;
        logic signed [MINE_W-1:0] min_energy;
        logic [IND_W-1:0]         indicator_column;
    } bbg_cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    // One classified reading, ready for column expansion
    typedef struct packed {
        logic signed [TIP_W-1:0] tip;
        logic [IND_W-1:0]        ind;
        glyph_t                  tip_glyph;
        glyph_t                  ind_glyph;
        light_t                  light;
    } bar_rec_t;

endpackage

// File: rtl/core/bipolar_bar_graph_columns.sv
// ============================================================================
// bipolar_bar_graph_columns
// Signed power reading to per-column glyph codes of a bipolar LCD bar graph.
// ============================================================================
// Usage
//   Input queue: drive energy and raise push; the reading is taken on a clock
//   edge with push high and full low. Output queue: while empty is low the
//   oldest column transaction (column, glyph, backlight, last) is on the
//   ports; pop on an edge with empty low takes it. Each reading yields one
//   transaction per column, first column to last, last=1 on the final one.
//   Configuration: APB write of max_energy (0x0), min_energy (0x4) and
//   indicator_column (0x8); write only while the block is idle.
// Timing
//   The front takes a reading, then runs three divisions on the shared
//   divider (4 quotient bits per cycle) and pushes the classified record.
//   The back emits one column per cycle while pop is high or the output
//   register is empty, 14 columns per reading. A two-entry queue between
//   front and back lets the front take the next reading while the back
//   still emits the previous row.
// Reset and stalls
//   Reset empties both queues and loads the register defaults (100, -50, 8).
//   Holding pop low freezes the output register; the back, then the queue,
//   then the front fill up and full rises. No transaction is lost.
// ============================================================================
module bipolar_bar_graph_columns
    import bbg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // reading input
    input  logic                       push,
    output logic                       full,
    input  logic signed [ENERGY_W-1:0] energy,
    // column output
    input  logic                       pop,
    output logic                       empty,
    output logic [COL_W-1:0]           column,
    output logic [GLYPH_W-1:0]         glyph,
    output logic [LIGHT_W-1:0]         backlight,
    output logic                       last,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    bbg_cfg_t         cfg_reg, cfg_next;
    logic             cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    div_req_t div_req;
    div_rsp_t div_rsp;
    bar_rec_t push_rec, pop_rec;
    logic     q_push, q_full, q_pop, q_empty;

    // ---------------- configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_MAX_ENERGY: cfg_next.max_energy       = pwdata[MAXE_W-1:0];
                REG_MIN_ENERGY: cfg_next.min_energy       = $signed(pwdata[MINE_W-1:0]);
                REG_INDICATOR:  cfg_next.indicator_column = pwdata[IND_W-1:0];
                default:        cfg_next = cfg_reg;   // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAX_ENERGY: prdata = {{(PDATA_W - MAXE_W){1'b0}}, cfg_reg.max_energy};
            REG_MIN_ENERGY: prdata = {{(PDATA_W - MINE_W){cfg_reg.min_energy[MINE_W-1]}},
                                      cfg_reg.min_energy};
            REG_INDICATOR:  prdata = {{(PDATA_W - IND_W){1'b0}}, cfg_reg.indicator_column};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_energy       <= MAX_ENERGY_RST;
            cfg_reg.min_energy       <= MIN_ENERGY_RST;
            cfg_reg.indicator_column <= INDICATOR_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    // ---------------- front: accept and classify
    bbg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .energy  (energy),
        .full    (full),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .q_push  (q_push),
        .q_rec   (push_rec),
        .q_full  (q_full)
    );

    // shared iterative divider used by the front
    bbg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- decoupling queue
    bbg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty)
    );

    // ---------------- back: column expansion and output register
    bbg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rec     (pop_rec),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .column    (column),
        .glyph     (glyph),
        .backlight (backlight),
        .last      (last)
    );

endmodule

// File: rtl/core/bbg_div.sv
// ============================================================================
// bbg_div
// Iterative unsigned restoring divider, DIV_STEP quotient bits per cycle.
// ============================================================================
module bbg_div
    import bbg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_PAD-1:0]   quo_reg, quo_next;
    logic [DIV_PAD-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]     den_reg, den_next;
    logic [DIV_PAD-1:0]   quo_step, rem_step, den_ext;

    // DIV_STEP shift/subtract steps on the current partial remainder
    always_comb
    begin
        quo_step = quo_reg;
        rem_step = rem_reg;
        den_ext  = {{(DIV_PAD - DIV_W){1'b0}}, den_reg};
        for (int i = 0; i < DIV_STEP; i++)
        begin
            rem_step = {rem_step[DIV_PAD-2:0], quo_step[DIV_PAD-1]};
            quo_step = {quo_step[DIV_PAD-2:0], 1'b0};
            if (rem_step >= den_ext)
            begin
                rem_step    = rem_step - den_ext;
                quo_step[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_ITER);
            quo_next  = {{(DIV_PAD - DIV_W){1'b0}}, req.num};
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            quo_next = quo_step;
            rem_next = rem_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // Result is the output of the final iteration
    assign rsp.done = busy_reg && (cnt_reg == DIV_CNT_W'(1));
    assign rsp.quo  = quo_step[DIV_W-1:0];
    assign rsp.rem  = rem_step[DIV_W-1:0];

endmodule

// File: rtl/core/bbg_front.sv
// ============================================================================
// bbg_front
// Accepts a reading and classifies it: scale, tip column, tip glyph, indicator glyph, backlight.
// ============================================================================
module bbg_front
    import bbg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bbg_cfg_t                   cfg,
    input  logic                       push,
    input  logic signed [ENERGY_W-1:0] energy,
    output logic                       full,
    output div_req_t                   div_req,
    input  div_rsp_t                   div_rsp,
    output logic                       q_push,
    output bar_rec_t                   q_rec,
    input  logic                       q_full
);

    front_state_t state_reg, state_next;

    logic                    neg_reg, neg_next;
    logic [DIV_W-1:0]        mag_reg, mag_next;
    logic [IND_W-1:0]        ind_reg, ind_next;
    light_t                  light_reg, light_next;
    glyph_t                  ind_glyph_reg, ind_glyph_next;
    logic [DIV_W-1:0]        scale_reg, scale_next;
    logic [STEP5_W-1:0]      step5_reg, step5_next;
    logic signed [TIP_W-1:0] tip_reg, tip_next;
    glyph_t                  tip_glyph_reg, tip_glyph_next;

    logic signed [ENERGY_W:0] e_w, max_w, half_w, min_w;
    logic signed [SPAN_W-1:0] ind_s, pos_span, neg_span, span_c;
    logic [DIV_W-1:0]         mag_in, mag_min, num1, den1, scale_c;
    logic [PROD_W-1:0]        prod;
    logic [STEP5_W-1:0]       step5_raw;
    logic signed [TIP_W-1:0]  quo_s;

    function automatic logic [DIV_W-1:0] mag11(input logic signed [ENERGY_W-1:0] v);
        logic signed [ENERGY_W:0] w;
        w = {v[ENERGY_W-1], v};
        if (w < 0)
            w = -w;
        return w[DIV_W-1:0];
    endfunction

    // ---------------- classification of the incoming reading
    always_comb
    begin
        e_w    = {energy[ENERGY_W-1], energy};
        max_w  = {{(ENERGY_W + 1 - MAXE_W){1'b0}}, cfg.max_energy};
        half_w = {{(ENERGY_W + 2 - MAXE_W){1'b0}}, cfg.max_energy[MAXE_W-1:1]};
        min_w  = {cfg.min_energy[MINE_W-1], cfg.min_energy};
        mag_in  = mag11(energy);
        mag_min = mag11(cfg.min_energy);

        ind_s    = SPAN_W'(cfg.indicator_column);
        pos_span = SPAN_W'(LAST_COLUMN) - ind_s;
        neg_span = ind_s - SPAN_W'(FIRST_COLUMN - 1);
        span_c   = energy[ENERGY_W-1] ? neg_span : pos_span;
        if (span_c < SPAN_W'(1))
            span_c = SPAN_W'(1);
        // a non-negative left full scale gives a scale of zero, clamped to 1
        num1 = !energy[ENERGY_W-1] ? DIV_W'(cfg.max_energy) :
               (cfg.min_energy[MINE_W-1] ? mag_min : '0);
        den1 = DIV_W'($unsigned(span_c));

        // scale below 1 clamps to 1
        scale_c = (div_rsp.quo == '0) ? DIV_W'(1) : div_rsp.quo;

        prod      = PROD_W'(scale_reg) * PROD_W'(DIV5_MUL);
        step5_raw = prod[DIV5_SHIFT +: STEP5_W];

        quo_s = neg_reg ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
    end

    // ---------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (push) state_next = F_SCALE;
            F_SCALE: if (div_rsp.done) state_next = F_QUOT;
            F_QUOT:  if (div_rsp.done) state_next = F_PART;
            F_PART:  if (div_rsp.done) state_next = F_PUSH;
            F_PUSH:  if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // ---------------- outputs
    always_comb
    begin
        full    = 1'b1;
        q_push  = 1'b0;
        div_req = '0;
        case (state_reg)
            F_IDLE:
            begin
                full          = 1'b0;
                div_req.start = push;
                div_req.num   = num1;
                div_req.den   = den1;
            end
            F_SCALE:
            begin
                div_req.start = div_rsp.done;
                div_req.num   = mag_reg;
                div_req.den   = scale_c;
            end
            F_QUOT:
            begin
                div_req.start = div_rsp.done;
                div_req.num   = div_rsp.rem;
                div_req.den   = DIV_W'(step5_reg);
            end
            F_PUSH:  q_push = !q_full;
            default: q_push = 1'b0;
        endcase
    end

    // ---------------- datapath
    always_comb
    begin
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        ind_next       = ind_reg;
        light_next     = light_reg;
        ind_glyph_next = ind_glyph_reg;
        scale_next     = scale_reg;
        tip_next       = tip_reg;
        tip_glyph_next = tip_glyph_reg;
        step5_next     = (step5_raw == '0) ? STEP5_W'(1) : step5_raw;

        if (state_reg == F_IDLE && push)
        begin
            neg_next = energy[ENERGY_W-1];
            mag_next = mag_in;
            ind_next = cfg.indicator_column;

            if (e_w <= 0 && e_w >= min_w)
                light_next = L_GREEN;
            else if (e_w > 0 && e_w <= half_w)
                light_next = L_YELLOW;
            else if (e_w > half_w && e_w <= max_w)
                light_next = L_RED;
            else
                light_next = L_NONE;

            if (e_w < -(ENERGY_W + 1)'(IND_SWING))
                ind_glyph_next = G_IND_NEG;
            else if (e_w > (ENERGY_W + 1)'(IND_SWING))
                ind_glyph_next = G_IND_POS;
            else
                ind_glyph_next = G_IND;
        end

        if (state_reg == F_SCALE && div_rsp.done)
            scale_next = scale_c;

        if (state_reg == F_QUOT && div_rsp.done)
            tip_next = quo_s + $signed(TIP_W'(ind_reg));

        if (state_reg == F_PART && div_rsp.done)
        begin
            if (div_rsp.quo == '0)
                tip_glyph_next = G_BLANK;
            else if (div_rsp.quo <= DIV_W'(HALF_LIMIT))
                tip_glyph_next = neg_reg ? G_NEG_HALF : G_POS_HALF;
            else
                tip_glyph_next = G_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        ind_reg       <= ind_next;
        light_reg     <= light_next;
        ind_glyph_reg <= ind_glyph_next;
        scale_reg     <= scale_next;
        step5_reg     <= step5_next;
        tip_reg       <= tip_next;
        tip_glyph_reg <= tip_glyph_next;
    end

    assign q_rec.tip       = tip_reg;
    assign q_rec.ind       = ind_reg;
    assign q_rec.tip_glyph = tip_glyph_reg;
    assign q_rec.ind_glyph = ind_glyph_reg;
    assign q_rec.light     = light_reg;

endmodule

// File: rtl/core/bbg_queue.sv
// ============================================================================
// bbg_queue
// Short register queue of classified readings between front and back.
// ============================================================================
module bbg_queue
    import bbg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bar_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output bar_rec_t pop_rec,
    output logic     empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    bar_rec_t         entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

// File: rtl/core/bbg_back.sv
// ============================================================================
// bbg_back
// Expands one classified reading into a glyph per display column.
// ============================================================================
module bbg_back
    import bbg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bar_rec_t           q_rec,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [COL_W-1:0]   column,
    output logic [GLYPH_W-1:0] glyph,
    output logic [LIGHT_W-1:0] backlight,
    output logic               last
);

    logic               active_reg, active_next;
    bar_rec_t           cur_reg, cur_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               out_valid_reg, out_valid_next;
    logic [COL_W-1:0]   column_reg, column_next;
    glyph_t             glyph_reg, glyph_next;
    light_t             light_reg, light_next;
    logic               last_reg, last_next;

    logic                    advance, emit, fin, load;
    logic signed [TIP_W-1:0] col_s, ind_s, tip_s;
    glyph_t                  col_glyph;

    assign advance = !out_valid_reg || pop;
    assign emit    = active_reg && advance;
    assign fin     = emit && (col_reg == COL_W'(LAST_COLUMN));
    assign load    = !q_empty && (!active_reg || fin);
    assign q_pop   = load;

    // glyph of the current column
    always_comb
    begin
        col_s = $signed(TIP_W'(col_reg));
        ind_s = $signed(TIP_W'(cur_reg.ind));
        tip_s = cur_reg.tip;
        if (col_reg == COL_W'(cur_reg.ind))
            col_glyph = cur_reg.ind_glyph;
        else if ((col_s > ind_s && col_s <= tip_s) || (col_s < ind_s && col_s >= tip_s))
            col_glyph = (col_s == tip_s) ? cur_reg.tip_glyph : G_FULL;
        else
            col_glyph = G_SPACE;
    end

    always_comb
    begin
        active_next    = active_reg;
        cur_next       = cur_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        column_next    = column_reg;
        glyph_next     = glyph_reg;
        light_next     = light_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            column_next    = col_reg;
            glyph_next     = col_glyph;
            light_next     = cur_reg.light;
            last_next      = (col_reg == COL_W'(LAST_COLUMN));
        end
        else if (pop)
            out_valid_next = 1'b0;

        if (load)
        begin
            active_next = 1'b1;
            cur_next    = q_rec;
            col_next    = COL_W'(FIRST_COLUMN);
        end
        else if (fin)
            active_next = 1'b0;
        else if (emit)
            col_next = col_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        col_reg    <= col_next;
        column_reg <= column_next;
        glyph_reg  <= glyph_next;
        light_reg  <= light_next;
        last_reg   <= last_next;
    end

    assign empty     = !out_valid_reg;
    assign column    = column_reg;
    assign glyph     = glyph_reg;
    assign backlight = light_reg;
    assign last      = last_reg;

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (col_reg >= COL_W'(FIRST_COLUMN) && col_reg <= COL_W'(LAST_COLUMN)))
        else $error("column counter out of row");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !fin) |=> (active_reg && col_reg == $past(col_reg) + 1'b1))
        else $error("column skipped or repeated");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (active_reg && col_reg == COL_W'(FIRST_COLUMN)))
        else $error("new row did not start at first column");

    a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && q_empty) |=> !active_reg)
        else $error("row continued past last column");

endmodule
